[sv/lpht_pkg.sv]
package lpht_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int INIT_SIZE_DEF = 16;

  localparam int CMD_W   = 2;
  localparam int KEY_W   = 31;
  localparam int PAY_W   = 32;
  localparam int STAT_W  = 2;
  localparam int SLOT_W  = 10;
  localparam int SIZE_W  = 11;
  localparam int ENTRY_W = 1 + KEY_W + PAY_W;

  localparam int ENT_OCC = ENTRY_W - 1;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [SIZE_W-1:0] size_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

endpackage

[sv/lpht_mod.sv]
module lpht_mod #(
  parameter int SW = 11
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [lpht_pkg::KEY_W-1:0] dividend,
  input  logic [SW-1:0]            divisor,
  output logic                     done,
  output logic [SW-1:0]            rem
);

  localparam int CW = $clog2(lpht_pkg::KEY_W);

  logic                       run_r, run_nxt;
  logic                       done_r, done_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [lpht_pkg::KEY_W-1:0] dvd_r, dvd_nxt;
  logic [SW-1:0]              div_r, div_nxt;
  logic [SW:0]                rem_r, rem_nxt;
  logic [SW:0]                trial;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    trial    = {rem_r[SW-1:0], dvd_r[lpht_pkg::KEY_W-1]};
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CW'(lpht_pkg::KEY_W - 1);
      dvd_nxt = dividend;
      div_nxt = divisor;
      rem_nxt = '0;
    end else if (run_r) begin
      if (trial >= {1'b0, div_r}) begin
        trial = trial - {1'b0, div_r};
      end
      rem_nxt = trial;
      dvd_nxt = {dvd_r[lpht_pkg::KEY_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[SW-1:0];

endmodule

[sv/linear_probe_hash_table_core.sv]
// Keyed record table with insert, delete and find commands, one at a time. A
// command is taken when start is high and busy is low; its single result is
// shown on the out_ ports for exactly one cycle with out_valid high and must
// be captured then, as the receiver cannot stall the block. The home slot is
// found by a bit-serial modulo unit, then each probed slot takes a read state
// and a check state on the table memory (one write port, one read port). An
// insert that pushes the load to 3/4 or more doubles the size, if that fits in
// CAPACITY, and rehashes through a spare memory: clear the spare, read each old
// slot, hash and probe each live entry into the spare, then copy back. After
// reset, and after each write to the size register, a clearing pass over all
// CAPACITY slots runs while busy is high.
module linear_probe_hash_table_core #(
  parameter int CAPACITY = lpht_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [lpht_pkg::CMD_W-1:0]    in_command,
  input  logic [lpht_pkg::KEY_W-1:0]    in_account_number,
  input  logic [lpht_pkg::PAY_W-1:0]    in_record_payload,
  output logic                          out_valid,
  output logic [lpht_pkg::STAT_W-1:0]   out_status,
  output logic [lpht_pkg::PAY_W-1:0]    out_found_payload,
  output logic [lpht_pkg::SLOT_W-1:0]   out_slot_index,
  output logic [lpht_pkg::SIZE_W-1:0]   out_size_in_use,
  input  logic                          cfg_we,
  input  logic [lpht_pkg::SIZE_W-1:0]   cfg_wdata
);

  localparam int SW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int EW = lpht_pkg::ENTRY_W;
  localparam int KW = lpht_pkg::KEY_W;
  localparam int PW = lpht_pkg::PAY_W;
  localparam int INIT_CL =
    (lpht_pkg::INIT_SIZE_DEF > CAPACITY) ? CAPACITY : lpht_pkg::INIT_SIZE_DEF;

  typedef enum logic [14:0] {
    S_CLEAR = 15'h0001,
    S_IDLE  = 15'h0002,
    S_HASH  = 15'h0004,
    S_RD    = 15'h0008,
    S_CHK   = 15'h0010,
    S_WR    = 15'h0020,
    S_OUT   = 15'h0040,
    R_SCLR  = 15'h0080,
    R_RDM   = 15'h0100,
    R_CHKM  = 15'h0200,
    R_MOD   = 15'h0400,
    R_RDS   = 15'h0800,
    R_CHKS  = 15'h1000,
    R_CPR   = 15'h2000,
    R_CPW   = 15'h4000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [SW-1:0]                size_r, size_nxt;
  logic [SW-1:0]                new_size_r, new_size_nxt;
  logic [SW-1:0]                cnt_r, cnt_nxt;
  logic [SW-1:0]                p_r, p_nxt;
  logic [SW-1:0]                c_r, c_nxt;
  logic [SW-1:0]                i_r, i_nxt;
  logic [lpht_pkg::CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [KW-1:0]                key_r, key_nxt;
  logic [PW-1:0]                pay_r, pay_nxt;
  logic [EW-1:0]                ent_r, ent_nxt;
  lpht_pkg::status_t            res_status_r, res_status_nxt;
  logic [PW-1:0]                res_found_r, res_found_nxt;
  logic [AW-1:0]                res_slot_r, res_slot_nxt;

  logic [EW-1:0] main_mem [CAPACITY];
  logic [EW-1:0] spare_mem [CAPACITY];
  logic          main_we, main_re, spare_we, spare_re;
  logic [AW-1:0] main_wa, main_ra, spare_wa, spare_ra;
  logic [EW-1:0] main_wd, main_rd, spare_wd, spare_rd;

  logic          mod_start, mod_done;
  logic [KW-1:0] mod_dvd;
  logic [SW-1:0] mod_div, mod_rem;

  logic [SW-1:0] cfg_size;
  logic [SW-1:0] cnt_inc;
  logic [SW+1:0] load4, load3;
  logic [SW:0]   dbl;
  logic          hit;

  lpht_mod #(.SW(SW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (mod_div),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (main_we) main_mem[main_wa] <= main_wd;
    if (main_re) main_rd <= main_mem[main_ra];
  end

  always_ff @(posedge clk) begin
    if (spare_we) spare_mem[spare_wa] <= spare_wd;
    if (spare_re) spare_rd <= spare_mem[spare_ra];
  end

  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_size = SW'(1);
    end else if (int'(cfg_wdata) > CAPACITY) begin
      cfg_size = SW'(CAPACITY);
    end else begin
      cfg_size = SW'(cfg_wdata);
    end
  end

  assign cnt_inc = cnt_r + 1'b1;
  assign load4   = {cnt_inc, 2'b00};
  assign load3   = {1'b0, size_r, 1'b0} + {2'b00, size_r};
  assign dbl     = {size_r, 1'b0};
  assign hit     = main_rd[lpht_pkg::ENT_OCC] && (main_rd[EW-2:PW] == key_r);

  assign mod_dvd = (state_r == S_IDLE) ? in_account_number : main_rd[EW-2:PW];
  assign mod_div = (state_r == S_IDLE) ? size_r : new_size_r;

  always_comb begin
    state_nxt      = state_r;
    size_nxt       = size_r;
    new_size_nxt   = new_size_r;
    cnt_nxt        = cnt_r;
    p_nxt          = p_r;
    c_nxt          = c_r;
    i_nxt          = i_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    pay_nxt        = pay_r;
    ent_nxt        = ent_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_slot_nxt   = res_slot_r;
    main_we        = 1'b0;
    main_wa        = '0;
    main_wd        = '0;
    main_re        = 1'b0;
    main_ra        = p_r[AW-1:0];
    spare_we       = 1'b0;
    spare_wa       = '0;
    spare_wd       = '0;
    spare_re       = 1'b0;
    spare_ra       = p_r[AW-1:0];
    mod_start      = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        main_we = 1'b1;
        main_wa = c_r[AW-1:0];
        c_nxt   = c_r + 1'b1;
        if (c_r == SW'(CAPACITY - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_nxt        = in_command;
          key_nxt        = in_account_number;
          pay_nxt        = in_record_payload;
          res_status_nxt = lpht_pkg::ST_NOT_FOUND;
          res_found_nxt  = '0;
          res_slot_nxt   = '0;
          if (in_command == lpht_pkg::CMD_INSERT || in_command == lpht_pkg::CMD_DELETE ||
              in_command == lpht_pkg::CMD_FIND) begin
            mod_start = 1'b1;
            state_nxt = S_HASH;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_HASH: begin
        if (mod_done) begin
          p_nxt     = mod_rem;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        main_re   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (cmd_r == lpht_pkg::CMD_INSERT) begin
          if (!main_rd[lpht_pkg::ENT_OCC]) begin
            res_slot_nxt = p_r[AW-1:0];
            state_nxt    = S_WR;
          end else if (p_r + 1'b1 < size_r) begin
            p_nxt     = p_r + 1'b1;
            state_nxt = S_RD;
          end else if (int'(size_r) >= CAPACITY) begin
            res_status_nxt = lpht_pkg::ST_FULL;
            state_nxt      = S_OUT;
          end else begin
            res_slot_nxt = size_r[AW-1:0];
            size_nxt     = size_r + 1'b1;
            state_nxt    = S_WR;
          end
        end else if (hit) begin
          res_status_nxt = lpht_pkg::ST_OK;
          res_slot_nxt   = p_r[AW-1:0];
          if (cmd_r == lpht_pkg::CMD_FIND) begin
            res_found_nxt = main_rd[PW-1:0];
          end else begin
            main_we = 1'b1;
            main_wa = p_r[AW-1:0];
            main_wd = main_rd & ~(EW'(1) << lpht_pkg::ENT_OCC);
            if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
          end
          state_nxt = S_OUT;
        end else if (p_r + 1'b1 < size_r) begin
          p_nxt     = p_r + 1'b1;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_WR: begin
        main_we        = 1'b1;
        main_wa        = res_slot_r;
        main_wd        = {1'b1, key_r, pay_r};
        cnt_nxt        = cnt_inc;
        res_status_nxt = lpht_pkg::ST_OK;
        if (load4 >= load3 && int'(dbl) <= CAPACITY) begin
          new_size_nxt = dbl[SW-1:0];
          c_nxt        = '0;
          state_nxt    = R_SCLR;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      R_SCLR: begin
        if (c_r >= new_size_r) begin
          i_nxt     = '0;
          state_nxt = R_RDM;
        end else begin
          spare_we = 1'b1;
          spare_wa = c_r[AW-1:0];
          c_nxt    = c_r + 1'b1;
        end
      end
      R_RDM: begin
        if (i_r >= size_r) begin
          c_nxt     = '0;
          state_nxt = R_CPR;
        end else begin
          main_re   = 1'b1;
          main_ra   = i_r[AW-1:0];
          state_nxt = R_CHKM;
        end
      end
      R_CHKM: begin
        if (main_rd[lpht_pkg::ENT_OCC]) begin
          ent_nxt   = main_rd;
          mod_start = 1'b1;
          state_nxt = R_MOD;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = R_RDM;
        end
      end
      R_MOD: begin
        if (mod_done) begin
          p_nxt     = mod_rem;
          state_nxt = R_RDS;
        end
      end
      R_RDS: begin
        spare_re  = 1'b1;
        state_nxt = R_CHKS;
      end
      R_CHKS: begin
        if (!spare_rd[lpht_pkg::ENT_OCC]) begin
          spare_we  = 1'b1;
          spare_wa  = p_r[AW-1:0];
          spare_wd  = ent_r;
          i_nxt     = i_r + 1'b1;
          state_nxt = R_RDM;
        end else if (p_r + 1'b1 < new_size_r) begin
          p_nxt     = p_r + 1'b1;
          state_nxt = R_RDS;
        end else if (int'(new_size_r) >= CAPACITY) begin
          // rehash dropped, old table stays
          state_nxt = S_OUT;
        end else begin
          spare_we     = 1'b1;
          spare_wa     = new_size_r[AW-1:0];
          spare_wd     = ent_r;
          new_size_nxt = new_size_r + 1'b1;
          i_nxt        = i_r + 1'b1;
          state_nxt    = R_RDM;
        end
      end
      R_CPR: begin
        if (c_r >= new_size_r) begin
          size_nxt  = new_size_r;
          state_nxt = S_OUT;
        end else begin
          spare_re  = 1'b1;
          spare_ra  = c_r[AW-1:0];
          state_nxt = R_CPW;
        end
      end
      R_CPW: begin
        main_we   = 1'b1;
        main_wa   = c_r[AW-1:0];
        main_wd   = spare_rd;
        c_nxt     = c_r + 1'b1;
        state_nxt = R_CPR;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      state_nxt = S_CLEAR;
      c_nxt     = '0;
      size_nxt  = cfg_size;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      size_r  <= SW'(INIT_CL);
      cnt_r   <= '0;
      c_r     <= '0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
      cnt_r   <= cnt_nxt;
      c_r     <= c_nxt;
    end
    new_size_r   <= new_size_nxt;
    p_r          <= p_nxt;
    i_r          <= i_nxt;
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    pay_r        <= pay_nxt;
    ent_r        <= ent_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_slot_r   <= res_slot_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = (state_r == S_OUT);
  assign out_status        = res_status_r;
  assign out_found_payload = res_found_r;
  assign out_slot_index    = lpht_pkg::slot_t'(res_slot_r);
  assign out_size_in_use   = lpht_pkg::size_t'(size_r);

endmodule

[verif/lpht_checker.sv]
`timescale 1ns / 1ps

module lpht_checker
  import lpht_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [KEY_W-1:0]  in_account_number,
  input  logic [PAY_W-1:0]  in_record_payload,
  input  logic              out_valid,
  input  logic [STAT_W-1:0] out_status,
  input  logic [PAY_W-1:0]  out_found_payload,
  input  logic [SLOT_W-1:0] out_slot_index,
  input  logic [SIZE_W-1:0] out_size_in_use,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending
);

  typedef struct {
    status_t          status;
    logic [PAY_W-1:0] found;
    slot_t            slot;
    size_t            size;
  } table_reply_t;

  table_reply_t reply_q[$];

  logic [KEY_W-1:0] tbl_key[CAPACITY];
  logic [PAY_W-1:0] tbl_pay[CAPACITY];
  bit               tbl_occ[CAPACITY];
  logic [KEY_W-1:0] sp_key[CAPACITY];
  logic [PAY_W-1:0] sp_pay[CAPACITY];
  bit               sp_occ[CAPACITY];
  int               init_size;
  int               cur_size;
  int               rec_count;

  function automatic int clamp_size(int v);
    if (v < 1) return 1;
    if (v > CAPACITY) return CAPACITY;
    return v;
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < CAPACITY; i++) tbl_occ[i] = 0;
    rec_count = 0;
    cur_size = init_size;
  endfunction

  function automatic int find_slot(logic [KEY_W-1:0] key);
    for (int i = int'(longint'(key) % cur_size); i < cur_size; i++)
      if (tbl_occ[i] && tbl_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void grow_table();
    int newsize;
    int j;
    if (cur_size * 2 > CAPACITY) return;
    newsize = cur_size * 2;
    for (int i = 0; i < CAPACITY; i++) sp_occ[i] = 0;
    for (int i = 0; i < cur_size; i++) begin
      if (!tbl_occ[i]) continue;
      for (j = int'(longint'(tbl_key[i]) % newsize); j < newsize; j++)
        if (!sp_occ[j]) break;
      if (j >= newsize) begin
        if (newsize >= CAPACITY) return;
        newsize++;
        j = newsize - 1;
      end
      sp_occ[j] = 1;
      sp_key[j] = tbl_key[i];
      sp_pay[j] = tbl_pay[i];
    end
    for (int i = 0; i < newsize; i++) begin
      tbl_occ[i] = sp_occ[i];
      if (sp_occ[i]) begin
        tbl_key[i] = sp_key[i];
        tbl_pay[i] = sp_pay[i];
      end
    end
    cur_size = newsize;
  endfunction

  function automatic table_reply_t run_command(logic [CMD_W-1:0] cmd,
                                               logic [KEY_W-1:0] key,
                                               logic [PAY_W-1:0] pay);
    table_reply_t r;
    int i;
    r.status = ST_NOT_FOUND;
    r.found = '0;
    r.slot = '0;
    case (cmd)
      CMD_INSERT: begin
        for (i = int'(longint'(key) % cur_size); i < cur_size; i++)
          if (!tbl_occ[i]) break;
        if (i >= cur_size) begin
          if (cur_size >= CAPACITY) begin
            r.status = ST_FULL;
            i = CAPACITY;
          end else begin
            cur_size++;
            i = cur_size - 1;
          end
        end
        if (i < CAPACITY) begin
          tbl_key[i] = key;
          tbl_pay[i] = pay;
          tbl_occ[i] = 1;
          rec_count++;
          r.status = ST_OK;
          r.slot = slot_t'(i);
          if (rec_count * 4 >= cur_size * 3) grow_table();
        end
      end
      CMD_DELETE: begin
        i = find_slot(key);
        if (i >= 0) begin
          tbl_occ[i] = 0;
          if (rec_count > 0) rec_count--;
          r.status = ST_OK;
          r.slot = slot_t'(i);
        end
      end
      CMD_FIND: begin
        i = find_slot(key);
        if (i >= 0) begin
          r.found = tbl_pay[i];
          r.status = ST_OK;
          r.slot = slot_t'(i);
        end
      end
      default: ;
    endcase
    r.size = size_t'(cur_size);
    return r;
  endfunction

  assign pending = reply_q.size();

  always @(posedge clk) begin
    table_reply_t e;
    if (!rst_n) begin
      init_size = clamp_size(INIT_SIZE_DEF);
      clear_table();
      reply_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        init_size = clamp_size(int'(cfg_wdata));
        clear_table();
      end
      if (out_valid) begin
        if (reply_q.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d slot %0d", $time,
                   out_status, out_slot_index);
          fail_count <= fail_count + 1;
        end else begin
          e = reply_q.pop_front();
          if (out_status !== e.status || out_found_payload !== e.found ||
              out_slot_index !== e.slot || out_size_in_use !== e.size) begin
            $display("%0t: mismatch expected st=%0d pay=%h slot=%0d size=%0d", $time,
                     e.status, e.found, e.slot, e.size);
            $display("%0t:          actual   st=%0d pay=%h slot=%0d size=%0d", $time,
                     out_status, out_found_payload, out_slot_index, out_size_in_use);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        reply_q.push_back(run_command(in_command, in_account_number, in_record_payload));
    end
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import lpht_pkg::*;

  localparam int LIMIT = 20_000_000;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              start = 0;
  logic              busy;
  logic [CMD_W-1:0]  in_command = '0;
  logic [KEY_W-1:0]  in_account_number = '0;
  logic [PAY_W-1:0]  in_record_payload = '0;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [PAY_W-1:0]  out_found_payload;
  logic [SLOT_W-1:0] out_slot_index;
  logic [SIZE_W-1:0] out_size_in_use;
  logic              cfg_we = 0;
  logic [SIZE_W-1:0] cfg_wdata = '0;
  int                fail_count;
  int                pending;
  int                cycles = 0;
  int                max_gap;
  logic [KEY_W-1:0]  key_pool[12];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  linear_probe_hash_table_core uut (
    .clk, .rst_n, .start, .busy, .in_command, .in_account_number, .in_record_payload,
    .out_valid, .out_status, .out_found_payload, .out_slot_index, .out_size_in_use,
    .cfg_we, .cfg_wdata
  );

  lpht_checker chk (
    .clk, .rst_n, .start, .busy, .in_command, .in_account_number, .in_record_payload,
    .out_valid, .out_status, .out_found_payload, .out_slot_index, .out_size_in_use,
    .cfg_we, .cfg_wdata, .fail_count, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL linear_probe_hash_table_core");
      $finish;
    end
  end

  // issue one item, wait for the edge that takes it, then idle for a random gap before returning
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                           logic [PAY_W-1:0] pay);
    int gap;
    start <= 1;
    in_command <= cmd;
    in_account_number <= key;
    in_record_payload <= pay;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic set_size(int v);
    start <= 0;
    do @(negedge clk); while (pending != 0 || busy);
    @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= size_t'(v);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_phase(int isize, int n_items, int ins_weight);
    int roll;
    logic [KEY_W-1:0] k;
    set_size(isize);
    max_gap = ($urandom_range(0, 2) == 0) ? 0 : 17;
    for (int i = 0; i < 12; i++)
      key_pool[i] = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom) :
                    KEY_W'($urandom_range(0, 80));
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(0, 99);
      k = key_pool[$urandom_range(0, 11)];
      if (roll < ins_weight)
        send_item(CMD_INSERT, ($urandom_range(0, 1) == 0) ? k : KEY_W'($urandom),
                  $urandom);
      else if (roll < ins_weight + (100 - ins_weight) / 2 - 3)
        send_item(CMD_FIND, k, $urandom);
      else if (roll < 95)
        send_item(CMD_DELETE, k, $urandom);
      else
        send_item(($urandom_range(0, 1) == 0) ? 2'd3 : CMD_FIND, KEY_W'($urandom), $urandom);
    end
  endtask

  initial begin
    max_gap = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_item(CMD_INSERT, '0, '0);
    send_item(CMD_INSERT, '1, '1);
    send_item(CMD_FIND, '0, '0);
    send_item(CMD_FIND, '1, '0);
    send_item(CMD_FIND, 31'd77, '0);
    send_item(CMD_INSERT, 31'd5, 32'h1111_1111);
    send_item(CMD_INSERT, 31'd5, 32'h2222_2222);
    send_item(CMD_FIND, 31'd5, '0);
    send_item(CMD_DELETE, 31'd5, '0);
    send_item(CMD_FIND, 31'd5, '0);
    send_item(CMD_INSERT, 31'd15, 32'hA5A5_5A5A);
    send_item(CMD_INSERT, 31'd15, 32'h5A5A_A5A5);
    send_item(CMD_DELETE, '0, '0);
    send_item(CMD_DELETE, 31'd1234, '0);
    send_item(2'd3, '1, '1);
    set_size(0);
    send_item(CMD_INSERT, 31'd7, 32'hDEAD_BEEF);
    send_item(CMD_FIND, 31'd7, '0);
    set_size(2047);
    send_item(CMD_INSERT, 31'd1023, 32'h0000_0001);
    send_item(CMD_INSERT, 31'd1023, 32'h0000_0002);
    send_item(CMD_FIND, 31'd1023, '0);
    set_size(1024);
    send_item(CMD_INSERT, 31'd2047, 32'hFFFF_0000);

    random_phase(520, 420, 90);
    random_phase(1, 110, 50);
    random_phase(2, 110, 45);
    random_phase(3, 100, 50);
    random_phase(16, 110, 55);
    random_phase($urandom_range(1, 40), 110, 50);
    random_phase(8, 110, 40);
    random_phase(5, 100, 60);
    random_phase($urandom_range(1, 100), 100, 50);
    random_phase(1024, 30, 60);

    start <= 0;
    do @(negedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS linear_probe_hash_table_core");
    end else begin
      $display("FAIL linear_probe_hash_table_core");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/lpht_pkg.sv
sv/lpht_mod.sv
sv/linear_probe_hash_table_core.sv
verif/lpht_checker.sv
verif/tb_top.sv
